[sv/binary_cross_entropy_accumulator_assert.svh]
// Assertion macros for the BCE accumulator checker.
`ifndef BINARY_CROSS_ENTROPY_ACCUMULATOR_ASSERT_SVH
`define BINARY_CROSS_ENTROPY_ACCUMULATOR_ASSERT_SVH

// same-cycle implication
`define BCE_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// next-cycle implication
`define BCE_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

[sv/bce_pkg.sv]
// Types, constants and log table for the BCE accumulator.
package bce_pkg;

    localparam int FRAC_BITS = 24;
    localparam int IN_W      = 25;
    localparam int ARG_W     = 26;
    localparam int TAB_BITS  = 6;
    localparam int TAB_N     = 1 << TAB_BITS;
    localparam int TAB_IW    = TAB_BITS + 1;
    localparam int TAB_W     = 17;
    localparam int DIFF_W    = 11;
    localparam int E_W       = 5;
    localparam int REM_W     = ARG_W - 1 - TAB_BITS;
    localparam int LN_W      = 23;
    localparam int PROD_W    = 49;
    localparam int S_W       = 50;
    localparam int LOSS_W    = 20;
    localparam int SUM_W     = 40;
    localparam int EPS_W     = 8;

    localparam logic [IN_W-1:0]   ONE_VAL  = IN_W'(1) << FRAC_BITS;
    localparam logic [LOSS_W-1:0] LOSS_MAX = '1;
    localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
    localparam logic [EPS_W-1:0]  EPS_RESET = 8'd17;

    typedef logic [TAB_N:0][TAB_W-1:0] ln_tab_t;

    typedef struct packed {
        logic [IN_W-1:0]  y;
        logic [ARG_W-1:0] a;
        logic [ARG_W-1:0] b;
        logic             last;
    } bce_item_t;

    typedef struct packed {
        logic [E_W-1:0]    e;
        logic [TAB_W-1:0]  lo;
        logic [DIFF_W-1:0] diff;
        logic [REM_W-1:0]  rem;
        logic [E_W-1:0]    sh;
    } ln_norm_t;

    // restoring shift-subtract divide, elaboration only
    function automatic logic [63:0] div64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[63:0], n[i]};
            if (r >= {1'b0, d})
            begin
                r = r - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // ln(1 + i/TAB_N) in Q16 via 2*atanh(t/(2+t)), Q30 truncating
    function automatic ln_tab_t build_tab();
        ln_tab_t tab;
        logic [63:0] t, z, z2, term, s, k;
        for (int i = 0; i <= TAB_N; i++)
        begin
            t = 64'(i) << (30 - TAB_BITS);
            z = div64(t << 30, (64'd2 << 30) + t);
            z2 = (z * z) >> 30;
            term = z;
            s = '0;
            k = 64'd1;
            for (int n = 0; n < 40; n++)
            begin
                if (term != '0)
                begin
                    s = s + div64(term, k);
                    term = (term * z2) >> 30;
                    k = k + 64'd2;
                end
            end
            tab[i] = TAB_W'((64'd2 * s + (64'd1 << 13)) >> 14);
        end
        return tab;
    endfunction

    localparam ln_tab_t LN_TAB = build_tab();

endpackage

[sv/bce_front.sv]
// Front end: epsilon register, input saturation and log-argument forming.
module bce_front
    import bce_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [EPS_W-1:0]  cfg_wdata,
    input  logic [IN_W-1:0]   label,
    input  logic [IN_W-1:0]   probability,
    input  logic              last,
    output bce_item_t         item
);

    logic [EPS_W-1:0] eps_reg;
    logic [IN_W-1:0]  y_sat;
    logic [IN_W-1:0]  p_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eps_reg <= EPS_RESET;
        else if (cfg_we)
            eps_reg <= cfg_wdata;
    end

    always_comb
    begin
        y_sat = (label > ONE_VAL) ? ONE_VAL : label;
        p_sat = (probability > ONE_VAL) ? ONE_VAL : probability;
        item.y    = y_sat;
        item.a    = ARG_W'(p_sat) + ARG_W'(eps_reg);
        item.b    = ARG_W'(ONE_VAL - p_sat) + ARG_W'(eps_reg);
        item.last = last;
    end

endmodule

[sv/bce_queue.sv]
// Small FIFO between front and back.
module bce_queue
    import bce_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_valid,
    output logic      wr_ready,
    input  bce_item_t wr_data,
    output logic      rd_valid,
    input  logic      rd_ready,
    output bce_item_t rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bce_item_t       mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_wr, do_rd;

    assign wr_ready = (count_reg != CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

[sv/bce_back.sv]
// Back end: log evaluation, loss, saturating total and output register.
module bce_back
    import bce_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  bce_item_t          q_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [LOSS_W-1:0]  m_loss,
    output logic [SUM_W-1:0]   m_total,
    output logic               m_sat,
    output logic               m_last
);

    typedef enum logic [2:0] {ST_IDLE, ST_INTERP, ST_MUL, ST_SUM, ST_OUT} state_t;

    state_t                   state_reg;
    ln_norm_t                 na_reg, nb_reg;
    logic [IN_W-1:0]          y_reg;
    logic                     last_reg;
    logic signed [LN_W-1:0]   ln_a_reg, ln_b_reg;
    logic signed [PROD_W-1:0] pa_reg, pb_reg;
    logic [LOSS_W-1:0]        loss_reg;
    logic [SUM_W-1:0]         total_reg;
    logic                     ovf_reg;
    logic                     m_valid_reg;
    logic [LOSS_W-1:0]        m_loss_reg;
    logic [SUM_W-1:0]         m_total_reg;
    logic                     m_sat_reg, m_last_reg;

    ln_norm_t                 na_next, nb_next;
    logic signed [LN_W-1:0]   ln_a_next, ln_b_next;
    logic signed [S_W-1:0]    s_val;
    logic [S_W-1:0]           neg_s;
    logic [S_W-FRAC_BITS-1:0] loss_wide;
    logic [LOSS_W-1:0]        loss_next;
    logic [SUM_W:0]           sum_wide;
    logic                     out_free;

    function automatic ln_norm_t ln_norm(input logic [ARG_W-1:0] x_in);
        ln_norm_t          r;
        logic [ARG_W-1:0]  x, frac;
        logic [E_W-1:0]    e;
        logic [TAB_BITS-1:0] idx;
        x = (x_in == '0) ? ARG_W'(1) : x_in;
        e = '0;
        for (int b = 0; b < ARG_W; b++)
        begin
            if (x[b])
                e = E_W'(b);
        end
        frac = x & ~(ARG_W'(1) << e);
        if (e >= E_W'(TAB_BITS))
        begin
            r.sh  = e - E_W'(TAB_BITS);
            idx   = TAB_BITS'(frac >> r.sh);
            r.rem = REM_W'(frac & ((ARG_W'(1) << r.sh) - ARG_W'(1)));
        end
        else
        begin
            r.sh  = '0;
            idx   = TAB_BITS'(frac << (E_W'(TAB_BITS) - e));
            r.rem = '0;
        end
        r.e    = e;
        r.lo   = LN_TAB[{1'b0, idx}];
        r.diff = DIFF_W'(LN_TAB[TAB_IW'(idx) + TAB_IW'(1)] - LN_TAB[{1'b0, idx}]);
        return r;
    endfunction

    function automatic logic signed [LN_W-1:0] ln_interp(input ln_norm_t n);
        logic [DIFF_W+REM_W-1:0] prod;
        logic signed [LN_W-1:0]  ea;
        logic signed [LN_W-1:0]  base;
        prod = (DIFF_W+REM_W)'(n.diff) * (DIFF_W+REM_W)'(n.rem);
        ea   = LN_W'(n.e) - LN_W'(FRAC_BITS);
        base = LN_W'(ea * $signed({1'b0, LN_TAB[TAB_N]}));
        return base + $signed(LN_W'(n.lo)) + $signed(LN_W'(prod >> n.sh));
    endfunction

    assign q_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_loss   = m_loss_reg;
    assign m_total  = m_total_reg;
    assign m_sat    = m_sat_reg;
    assign m_last   = m_last_reg;

    always_comb
    begin
        na_next   = ln_norm(q_data.a);
        nb_next   = ln_norm(q_data.b);
        ln_a_next = ln_interp(na_reg);
        ln_b_next = ln_interp(nb_reg);
        s_val     = S_W'(pa_reg) + S_W'(pb_reg);
        neg_s     = S_W'(0) - S_W'(s_val);
        loss_wide = (S_W-FRAC_BITS)'(neg_s >> FRAC_BITS);
        if (s_val >= 0)
            loss_next = '0;
        else if (loss_wide > (S_W-FRAC_BITS)'(LOSS_MAX))
            loss_next = LOSS_MAX;
        else
            loss_next = LOSS_W'(loss_wide);
        sum_wide = {1'b0, total_reg} + (SUM_W+1)'(loss_reg);
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                na_reg   <= na_next;
                nb_reg   <= nb_next;
                y_reg    <= q_data.y;
                last_reg <= q_data.last;
            end
            ST_INTERP:
            begin
                ln_a_reg <= ln_a_next;
                ln_b_reg <= ln_b_next;
            end
            ST_MUL:
            begin
                pa_reg <= $signed({1'b0, y_reg}) * ln_a_reg;
                pb_reg <= $signed({1'b0, ONE_VAL - y_reg}) * ln_b_reg;
            end
            ST_SUM:
                loss_reg <= loss_next;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            total_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            m_loss_reg  <= '0;
            m_total_reg <= '0;
            m_sat_reg   <= 1'b0;
            m_last_reg  <= 1'b0;
        end
        else
        begin
            m_valid_reg <= ((state_reg == ST_OUT) && out_free) ? 1'b1
                                                                : (m_valid_reg && !m_ready);
            case (state_reg)
                ST_IDLE:
                    if (q_valid)
                        state_reg <= ST_INTERP;
                ST_INTERP:
                    state_reg <= ST_MUL;
                ST_MUL:
                    state_reg <= ST_SUM;
                ST_SUM:
                    state_reg <= ST_OUT;
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        m_loss_reg  <= loss_reg;
                        m_last_reg  <= last_reg;
                        if (sum_wide >= (SUM_W+1)'(SUM_MAX))
                        begin
                            m_total_reg <= SUM_MAX;
                            m_sat_reg   <= 1'b1;
                            total_reg   <= last_reg ? '0 : SUM_MAX;
                            ovf_reg     <= !last_reg;
                        end
                        else
                        begin
                            m_total_reg <= SUM_W'(sum_wide);
                            m_sat_reg   <= ovf_reg;
                            total_reg   <= last_reg ? '0 : SUM_W'(sum_wide);
                            ovf_reg     <= last_reg ? 1'b0 : ovf_reg;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

[sv/binary_cross_entropy_accumulator.sv]
// Path from input request to result valid: queue write, then pop/normalize, interpolate,
// multiply, sum, output register; longer while the output stalls.
// The back-end log/multiply sequencer takes a new request only when idle, one at a time.
// The input queue keeps accepting, until it is full, while a result waits at the output.
// Reset (rst_n, async low) empties the queue, clears total and flag, epsilon = 17.
module binary_cross_entropy_accumulator
    import bce_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // label[24:0], probability[49:25], zero pad
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // sample_loss[19:0], running_total[59:20], zero pad
    output logic        m_axis_tuser,   // total_saturated
    output logic        m_axis_tlast
);

    bce_item_t          front_item, q_item;
    logic               q_valid, q_ready;
    logic [LOSS_W-1:0]  loss;
    logic [SUM_W-1:0]   total;

    bce_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .label       (s_axis_tdata[24:0]),
        .probability (s_axis_tdata[49:25]),
        .last        (s_axis_tlast),
        .item        (front_item)
    );

    bce_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (s_axis_tvalid),
        .wr_ready (s_axis_tready),
        .wr_data  (front_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_item)
    );

    bce_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_item),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_loss  (loss),
        .m_total (total),
        .m_sat   (m_axis_tuser),
        .m_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0, total, loss};

endmodule

[sv/bce_checker.sv]
// Port-level checker for the BCE accumulator, bound to the top level.
`include "binary_cross_entropy_accumulator_assert.svh"

module bce_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    `BCE_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `BCE_ASSERT_NEXT(a_out_stable, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    `BCE_ASSERT_NOW(a_total_ge_loss, clk, rst_n, m_axis_tvalid, m_axis_tdata[59:20] >= {20'b0, m_axis_tdata[19:0]})
    `BCE_ASSERT_NOW(a_max_flags, clk, rst_n, m_axis_tvalid && (m_axis_tdata[59:20] == 40'hFF_FFFF_FFFF), m_axis_tuser)

endmodule

bind binary_cross_entropy_accumulator bce_checker u_bce_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[tb/tb_binary_cross_entropy_accumulator.sv]
// Self-checking testbench for the binary cross-entropy loss accumulator.
`timescale 1ns / 1ps

module tb_binary_cross_entropy_accumulator;
    import bce_pkg::*;

    typedef struct packed {
        logic [24:0] label;
        logic [24:0] prob;
        logic        last;
    } sample_t;

    typedef struct packed {
        logic [19:0] loss;
        logic [39:0] total;
        logic        sat;
        logic        done;
    } loss_rec_t;

    localparam logic [24:0] ONE = 25'd1 << 24;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    sample_t   pending_q[$];
    loss_rec_t loss_q[$];
    longint unsigned ln_lut[65];
    logic [7:0]  eps_val;
    logic [39:0] acc_total;
    logic        acc_sat;
    int  errors;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_cycles;
    bit  running;

    binary_cross_entropy_accumulator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    initial
    begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    task automatic build_ln_lut();
        longint unsigned t, z, z2, term, s, k;
        for (int i = 0; i <= 64; i++)
        begin
            t = longint'(i) << 24;
            z = (t << 30) / ((64'd2 << 30) + t);
            z2 = (z * z) >> 30;
            term = z;
            s = 0;
            k = 1;
            while (term != 0)
            begin
                s += term / k;
                term = (term * z2) >> 30;
                k += 2;
            end
            ln_lut[i] = (2 * s + (1 << 13)) >> 14;
        end
    endtask

    function automatic longint fixed_ln(longint unsigned x);
        int e;
        int sh;
        longint unsigned frac, idx, rem, lo, hi, part;
        e = 0;
        if (x == 0)
            x = 1;
        for (int b = 0; b < 63; b++)
            if ((x >> b) & 1)
                e = b;
        frac = x - (64'd1 << e);
        if (e >= 6)
        begin
            sh = e - 6;
            idx = frac >> sh;
            rem = frac & ((64'd1 << sh) - 1);
        end
        else
        begin
            sh = 0;
            idx = frac << (6 - e);
            rem = 0;
        end
        idx &= 63;
        lo = ln_lut[idx];
        hi = ln_lut[idx + 1];
        part = ((hi - lo) * rem) >> sh;
        return longint'(e - 24) * longint'(ln_lut[64]) + longint'(lo + part);
    endfunction

    function automatic loss_rec_t predict_loss(sample_t smp);
        longint unsigned y, p, lv, sum;
        longint s;
        loss_rec_t r;
        y = smp.label > ONE ? ONE : smp.label;
        p = smp.prob > ONE ? ONE : smp.prob;
        s = longint'(y) * fixed_ln(p + eps_val)
          + longint'(ONE - y) * fixed_ln(ONE - p + eps_val);
        lv = 0;
        if (s < 0)
        begin
            lv = longint'(-s) >> 24;
            if (lv > 1048575)
                lv = 1048575;
        end
        sum = acc_total + lv;
        if (sum >= 64'hFF_FFFF_FFFF)
        begin
            sum = 64'hFF_FFFF_FFFF;
            acc_sat = 1'b1;
        end
        acc_total = sum[39:0];
        r.loss = lv[19:0];
        r.total = acc_total;
        r.sat = acc_sat;
        r.done = smp.last;
        if (smp.last)
        begin
            acc_total = '0;
            acc_sat = 1'b0;
        end
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tlast <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                void'(pending_q.pop_front());
            if ((!s_axis_tvalid || s_axis_tready) && running)
            begin
                if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    sample_t nx;
                    nx = pending_q[0];
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {6'd0, nx.prob, nx.label};
                    s_axis_tlast <= nx.last;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            else if (!running)
                s_axis_tvalid <= 1'b0;
        end
    end

    // expected results are made at acceptance
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            loss_q.push_back(predict_loss('{s_axis_tdata[24:0], s_axis_tdata[49:25],
                                            s_axis_tlast}));
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                loss_rec_t got, want;
                got = '{m_axis_tdata[19:0], m_axis_tdata[59:20], m_axis_tuser, m_axis_tlast};
                if (loss_q.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = loss_q.pop_front();
                    if (got.loss !== want.loss || got.total !== want.total
                        || got.sat !== want.sat || got.done !== want.done)
                    begin
                        $display("%0t: expected loss %h total %h sat %b done %b, got %h %h %b %b",
                                 $time, want.loss, want.total, want.sat, want.done,
                                 got.loss, got.total, got.sat, got.done);
                        errors++;
                    end
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= $urandom_range(99) >= recv_stall_pct;
        end
    end

    task automatic add_sample(logic [24:0] lb, logic [24:0] pr, logic lst);
        pending_q.push_back('{lb, pr, lst});
    endtask

    function automatic logic [24:0] rand_q124();
        case ($urandom_range(9))
            0: return ONE;
            1: return 25'($urandom_range(255));
            2: return ONE - 25'($urandom_range(255));
            3: return 25'h1FF_FFFF - 25'($urandom_range(1000));
            4: return $urandom_range(1) ? ONE : 25'd0;
            default: return 25'($urandom_range(32'h100_0000));
        endcase
    endfunction

    task automatic drain();
        while (pending_q.size() > 0 || loss_q.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_eps(logic [7:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        eps_val = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        errors = 0;
        running = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        eps_val = 8'd17;
        acc_total = '0;
        acc_sat = 1'b0;
        build_ln_lut();
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // edges and out-of-range values at reset epsilon, then edges at epsilon 0 and 255
        add_sample(ONE, ONE, 1'b0);
        add_sample(25'd0, 25'd0, 1'b0);
        add_sample(ONE, 25'd0, 1'b0);
        add_sample(25'd0, ONE, 1'b0);
        add_sample(25'h1FF_FFFF, 25'h1FF_FFFF, 1'b0);
        add_sample(ONE >> 1, ONE >> 1, 1'b0);
        add_sample(25'd1, 25'd1, 1'b1);
        running = 1;
        drain();
        write_eps(8'd0);
        add_sample(ONE, 25'd0, 1'b0);
        add_sample(25'd0, ONE, 1'b0);
        add_sample(25'd0, 25'd0, 1'b0);
        add_sample(25'h1AA_AAAA, 25'h155_5555, 1'b0);
        add_sample(25'h0AA_AAAA, 25'h055_5555, 1'b1);
        drain();
        write_eps(8'd255);
        add_sample(ONE, 25'd0, 1'b0);
        add_sample(25'd0, ONE, 1'b0);
        add_sample(25'd0, 25'd0, 1'b1);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            write_eps(ph == 5 ? 8'd255 : (ph == 4 ? 8'd0 : 8'($urandom_range(255))));
            for (int i = 0; i < 225; i++)
                add_sample(rand_q124(), rand_q124(), $urandom_range(15) == 0);
            if (ph == 0)
            begin
                repeat (5) @(posedge clk);
                hold_cycles = 300;
            end
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;

        // short batch of maximal losses
        write_eps(8'd0);
        for (int i = 0; i < 2; i++)
            add_sample(ONE, 25'd0, 1'b0);
        add_sample(ONE, 25'd0, 1'b1);
        drain();

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
